[design/assert_macros.svh]
// Assertion macros for the design files; only the top level includes them.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition is never true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[design/mibs_pkg.sv]
// Shared constants, types and helpers for the mask integral box-sum core.
// No dependencies; used by mibs_ctrl, mibs_dp and the top level.
package mibs_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROWC_W = $clog2(MAX_ROWS + 1);
    localparam int COLC_W = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);

    localparam int ENT_W  = $clog2(MAX_ROWS * MAX_COLS + 1) + 1;
    localparam int RSUM_W = $clog2(MAX_COLS + 1) + 1;
    localparam int ACC_W  = ENT_W + 2;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 8;
    localparam int POS_W     = 10;
    localparam int DIM_W     = 9;
    localparam int CRD_W     = 12;
    localparam int OUT_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_RESET  = 9'd256;

    localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
    localparam logic [OUT_W-1:0] SUM_MAX = 17'h1FFFF;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_A,
        ST_Q_B,
        ST_Q_C,
        ST_Q_D,
        ST_Q_ACC,
        ST_Q_OUT
    } t_state;

    typedef enum logic [2:0] {
        RD_ABOVE,
        RD_A,
        RD_B,
        RD_C,
        RD_D
    } t_rd_src;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic    take;
        t_rd_src rd_src;
        logic    wr;
        t_acc_op acc;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

endpackage

[design/mibs_ctrl.sv]
// Sequencer for pixel loads and four-read box queries.
// Depends on mibs_pkg; drives mibs_dp through t_dp_cmd.
module mibs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_command,
    input  mibs_pkg::t_dp_stat i_stat,
    output logic              o_ready,
    output mibs_pkg::t_dp_cmd  o_cmd
);

    mibs_pkg::t_state r_state;
    mibs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mibs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_ready          = 1'b0;
        o_cmd.take       = 1'b0;
        o_cmd.rd_src     = mibs_pkg::RD_ABOVE;
        o_cmd.wr         = 1'b0;
        o_cmd.acc        = mibs_pkg::ACC_HOLD;
        o_cmd.out_load   = 1'b0;
        case (r_state)
            mibs_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = (i_command == mibs_pkg::CMD_QUERY) ? mibs_pkg::ST_Q_A
                                                                 : mibs_pkg::ST_LD_RD;
                end
            end
            mibs_pkg::ST_LD_RD: begin
                o_cmd.rd_src = mibs_pkg::RD_ABOVE;
                n_state = mibs_pkg::ST_LD_WR;
            end
            mibs_pkg::ST_LD_WR: begin
                o_cmd.wr = 1'b1;
                n_state = mibs_pkg::ST_IDLE;
            end
            mibs_pkg::ST_Q_A: begin
                o_cmd.rd_src = mibs_pkg::RD_A;
                n_state = mibs_pkg::ST_Q_B;
            end
            mibs_pkg::ST_Q_B: begin
                o_cmd.rd_src = mibs_pkg::RD_B;
                o_cmd.acc = mibs_pkg::ACC_LOAD;
                n_state = mibs_pkg::ST_Q_C;
            end
            mibs_pkg::ST_Q_C: begin
                o_cmd.rd_src = mibs_pkg::RD_C;
                o_cmd.acc = mibs_pkg::ACC_SUB;
                n_state = mibs_pkg::ST_Q_D;
            end
            mibs_pkg::ST_Q_D: begin
                o_cmd.rd_src = mibs_pkg::RD_D;
                o_cmd.acc = mibs_pkg::ACC_SUB;
                n_state = mibs_pkg::ST_Q_ACC;
            end
            mibs_pkg::ST_Q_ACC: begin
                o_cmd.acc = mibs_pkg::ACC_ADD;
                n_state = mibs_pkg::ST_Q_OUT;
            end
            mibs_pkg::ST_Q_OUT: begin
                // hold the sum until the output register can take it
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = mibs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mibs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/mibs_dp.sv]
// Datapath: size registers, raster position, summed-area table memory,
// query corner clamping, four-corner accumulator and output register.
// Depends on mibs_pkg; commanded by mibs_ctrl.
module mibs_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mibs_pkg::t_dp_cmd                    i_cmd,
    output mibs_pkg::t_dp_stat                   o_stat,
    input  logic                                 i_cfg_valid,
    input  logic [mibs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mibs_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_command,
    input  logic [mibs_pkg::PIX_W-1:0]           i_pixel,
    input  logic                                 i_sof,
    input  logic signed [mibs_pkg::POS_W-1:0]    i_box_row,
    input  logic signed [mibs_pkg::POS_W-1:0]    i_box_col,
    input  logic [mibs_pkg::DIM_W-1:0]           i_box_rows,
    input  logic [mibs_pkg::DIM_W-1:0]           i_box_cols,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mibs_pkg::OUT_W-1:0]           o_out_data
);

    // size registers and effective sizes
    logic [mibs_pkg::CFG_W-1:0]  r_height;
    logic [mibs_pkg::CFG_W-1:0]  r_width;
    logic [mibs_pkg::ROWC_W-1:0] w_h;
    logic [mibs_pkg::COLC_W-1:0] w_w;

    // raster position
    logic [mibs_pkg::ROWC_W-1:0]        r_row;
    logic [mibs_pkg::COLC_W-1:0]        r_col;
    logic signed [mibs_pkg::RSUM_W-1:0] r_rsum;
    logic                               r_full;
    logic [mibs_pkg::ROWC_W-1:0]        n_row;
    logic [mibs_pkg::COLC_W-1:0]        n_col;
    logic signed [mibs_pkg::RSUM_W-1:0] n_rsum;
    logic                               n_full;

    // pending store
    logic [mibs_pkg::ROW_W-1:0]         r_st_row;
    logic [mibs_pkg::COL_W-1:0]         r_st_col;
    logic signed [mibs_pkg::RSUM_W-1:0] r_wsum;
    logic                               r_store;
    logic [mibs_pkg::ROW_W-1:0]         n_st_row;
    logic [mibs_pkg::COL_W-1:0]         n_st_col;
    logic signed [mibs_pkg::RSUM_W-1:0] n_wsum;
    logic                               n_store;

    // query corners
    logic [mibs_pkg::ROW_W-1:0] r_pa_row;
    logic [mibs_pkg::COL_W-1:0] r_pa_col;
    logic [mibs_pkg::ROW_W-1:0] r_pb_row;
    logic [mibs_pkg::COL_W-1:0] r_pb_col;
    logic [mibs_pkg::ROW_W-1:0] n_pa_row;
    logic [mibs_pkg::COL_W-1:0] n_pa_col;
    logic [mibs_pkg::ROW_W-1:0] n_pb_row;
    logic [mibs_pkg::COL_W-1:0] n_pb_col;

    // table memory
    logic signed [mibs_pkg::ENT_W-1:0] r_mem [mibs_pkg::MAX_ROWS * mibs_pkg::MAX_COLS];
    logic signed [mibs_pkg::ENT_W-1:0] r_rdata;
    logic [mibs_pkg::ADDR_W-1:0]       w_raddr;
    logic [mibs_pkg::ADDR_W-1:0]       w_waddr;
    logic signed [mibs_pkg::ENT_W-1:0] w_wdata;
    logic                              w_we;

    // accumulator and output
    logic signed [mibs_pkg::ACC_W-1:0] r_acc;
    logic signed [mibs_pkg::ACC_W-1:0] w_rd_ext;
    logic [mibs_pkg::OUT_W-1:0]        w_result;
    logic                              r_out_valid;
    logic [mibs_pkg::OUT_W-1:0]        r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= mibs_pkg::CFG_RESET;
            r_width  <= mibs_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mibs_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                mibs_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_height == '0) begin
            w_h = mibs_pkg::ROWC_W'(1);
        end else if (int'(r_height) > mibs_pkg::MAX_ROWS) begin
            w_h = mibs_pkg::ROWC_W'(mibs_pkg::MAX_ROWS);
        end else begin
            w_h = mibs_pkg::ROWC_W'(r_height);
        end
        if (r_width == '0) begin
            w_w = mibs_pkg::COLC_W'(1);
        end else if (int'(r_width) > mibs_pkg::MAX_COLS) begin
            w_w = mibs_pkg::COLC_W'(mibs_pkg::MAX_COLS);
        end else begin
            w_w = mibs_pkg::COLC_W'(r_width);
        end
    end

    // raster step for a pixel load: where it lands and where the next one goes
    always_comb begin
        logic [mibs_pkg::ROWC_W-1:0]        row0;
        logic [mibs_pkg::ROWC_W-1:0]        row1;
        logic [mibs_pkg::COLC_W-1:0]        col0;
        logic [mibs_pkg::COLC_W-1:0]        col1;
        logic [mibs_pkg::COLC_W-1:0]        col2;
        logic signed [mibs_pkg::RSUM_W-1:0] rs1;
        logic                               full0;
        row0  = i_sof ? '0 : r_row;
        col0  = i_sof ? '0 : r_col;
        rs1   = i_sof ? '0 : r_rsum;
        full0 = i_sof ? 1'b0 : r_full;
        row1  = row0;
        col1  = col0;
        col2  = col0;
        n_row   = row0;
        n_col   = col0;
        n_rsum  = rs1;
        n_full  = full0;
        n_store = 1'b0;
        if (!full0) begin
            if (col0 >= w_w) begin
                col1 = '0;
                row1 = row0 + 1'b1;
                rs1  = '0;
            end
            n_row  = row1;
            n_col  = col1;
            n_rsum = rs1;
            if (row1 >= w_h) begin
                n_full = 1'b1;
            end else begin
                n_store = 1'b1;
                if (col1 == '0) begin
                    rs1 = '0;
                end
                rs1 = (i_pixel == mibs_pkg::PIX_ON) ? rs1 + 2'sd1 : rs1 - 2'sd1;
                n_rsum = rs1;
                col2 = col1 + 1'b1;
                n_col = col2;
                if (col2 >= w_w) begin
                    n_col  = '0;
                    n_row  = row1 + 1'b1;
                    n_rsum = '0;
                    if (row1 + 1'b1 >= w_h) begin
                        n_full = 1'b1;
                    end
                end
            end
        end
        n_st_row = row1[mibs_pkg::ROW_W-1:0];
        n_st_col = col1[mibs_pkg::COL_W-1:0];
        n_wsum   = rs1;
    end

    // clamp the query corners into the image
    always_comb begin
        logic signed [mibs_pkg::CRD_W-1:0] x;
        logic signed [mibs_pkg::CRD_W-1:0] y;
        logic signed [mibs_pkg::CRD_W-1:0] hs;
        logic signed [mibs_pkg::CRD_W-1:0] ws;
        logic signed [mibs_pkg::CRD_W-1:0] px;
        logic signed [mibs_pkg::CRD_W-1:0] py;
        logic signed [mibs_pkg::CRD_W-1:0] xm;
        logic signed [mibs_pkg::CRD_W-1:0] ym;
        x  = mibs_pkg::CRD_W'(i_box_row);
        y  = mibs_pkg::CRD_W'(i_box_col);
        hs = $signed(mibs_pkg::CRD_W'(w_h));
        ws = $signed(mibs_pkg::CRD_W'(w_w));
        px = x + $signed(mibs_pkg::CRD_W'(i_box_rows)) - 2'sd1;
        py = y + $signed(mibs_pkg::CRD_W'(i_box_cols)) - 2'sd1;
        if (px < 0) begin
            px = '0;
        end else if (px > hs - 2'sd1) begin
            px = hs - 2'sd1;
        end
        if (py < 0) begin
            py = '0;
        end else if (py > ws - 2'sd1) begin
            py = ws - 2'sd1;
        end
        if (x < 1) begin
            xm = '0;
        end else if (x > hs) begin
            xm = hs - 2'sd1;
        end else begin
            xm = x - 2'sd1;
        end
        if (y < 1) begin
            ym = '0;
        end else if (y > ws) begin
            ym = ws - 2'sd1;
        end else begin
            ym = y - 2'sd1;
        end
        n_pa_row = px[mibs_pkg::ROW_W-1:0];
        n_pa_col = py[mibs_pkg::COL_W-1:0];
        n_pb_row = xm[mibs_pkg::ROW_W-1:0];
        n_pb_col = ym[mibs_pkg::COL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_rsum  <= '0;
            r_full  <= 1'b0;
            r_store <= 1'b0;
        end else if (i_cmd.take && i_command == mibs_pkg::CMD_LOAD) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_rsum  <= n_rsum;
            r_full  <= n_full;
            r_store <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            if (i_command == mibs_pkg::CMD_LOAD) begin
                r_st_row <= n_st_row;
                r_st_col <= n_st_col;
                r_wsum   <= n_wsum;
            end else begin
                r_pa_row <= n_pa_row;
                r_pa_col <= n_pa_col;
                r_pb_row <= n_pb_row;
                r_pb_col <= n_pb_col;
            end
        end
    end

    always_comb begin
        case (i_cmd.rd_src)
            mibs_pkg::RD_ABOVE: w_raddr = mibs_pkg::cell_addr(r_st_row - 1'b1, r_st_col);
            mibs_pkg::RD_A:     w_raddr = mibs_pkg::cell_addr(r_pa_row, r_pa_col);
            mibs_pkg::RD_B:     w_raddr = mibs_pkg::cell_addr(r_pb_row, r_pa_col);
            mibs_pkg::RD_C:     w_raddr = mibs_pkg::cell_addr(r_pa_row, r_pb_col);
            mibs_pkg::RD_D:     w_raddr = mibs_pkg::cell_addr(r_pb_row, r_pb_col);
            default:            w_raddr = mibs_pkg::cell_addr(r_pa_row, r_pa_col);
        endcase
    end

    // entry = row running sum + entry above (zero on the first row)
    assign w_waddr = mibs_pkg::cell_addr(r_st_row, r_st_col);
    assign w_wdata = mibs_pkg::ENT_W'(r_wsum) + ((r_st_row != '0) ? r_rdata : '0);
    assign w_we    = i_cmd.wr && r_store;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign w_rd_ext = mibs_pkg::ACC_W'(r_rdata);

    always_ff @(posedge i_clk) begin
        case (i_cmd.acc)
            mibs_pkg::ACC_LOAD: r_acc <= w_rd_ext;
            mibs_pkg::ACC_SUB:  r_acc <= r_acc - w_rd_ext;
            mibs_pkg::ACC_ADD:  r_acc <= r_acc + w_rd_ext;
            default:            r_acc <= r_acc;
        endcase
    end

    // non-positive gives zero, large sums saturate
    always_comb begin
        if (r_acc <= 0) begin
            w_result = '0;
        end else if (r_acc > $signed(mibs_pkg::ACC_W'(mibs_pkg::SUM_MAX))) begin
            w_result = mibs_pkg::SUM_MAX;
        end else begin
            w_result = r_acc[mibs_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= w_result;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

[design/mask_integral_box_sum_core.sv]
// Box sums over a +1/-1 mask held as a summed-area table in one memory with
// one read and one write port. A pixel load steps through accept, read the
// entry above and write; a box query steps through accept, four table reads
// through the one registered read port, final add and output load, and waits
// at the output load while the previous result still sits unread in the output
// register. The result register lets a new request be accepted while a result
// waits. Queries must only touch table entries written since reset. Sizes come
// from the configuration port: index 0 is image height, index 1 is image width.
`include "assert_macros.svh"

module mask_integral_box_sum_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] pixel_value, [17:8] box_row, [27:18] box_col,
    // [36:28] box_rows, [45:37] box_cols, [47:46] zero
    input  logic [47:0] s_axis_tdata,
    // [0] command, [1] start_of_frame
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [16:0] box_sum, [23:17] zero
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [mibs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mibs_pkg::CFG_W-1:0]     i_cfg_data
);

    mibs_pkg::t_dp_cmd  w_cmd;
    mibs_pkg::t_dp_stat w_stat;
    logic [mibs_pkg::OUT_W-1:0] w_sum;

    assign o_cfg_ready = 1'b1;

    mibs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_command (s_axis_tuser[0]),
        .i_stat    (w_stat),
        .o_ready   (s_axis_tready),
        .o_cmd     (w_cmd)
    );

    mibs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_command   (s_axis_tuser[0]),
        .i_pixel     (s_axis_tdata[7:0]),
        .i_sof       (s_axis_tuser[1]),
        .i_box_row   ($signed(s_axis_tdata[17:8])),
        .i_box_col   ($signed(s_axis_tdata[27:18])),
        .i_box_rows  (s_axis_tdata[36:28]),
        .i_box_cols  (s_axis_tdata[45:37]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (w_sum)
    );

    assign m_axis_tdata = {7'b0, w_sum};

    `ASSERT_CLK(a_one_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "request accepted while busy")
    `ASSERT_NEVER(a_no_overwrite, w_cmd.out_load && !w_stat.out_free, "result overwritten before taken")
    `ASSERT_CLK(a_valid_from_load, $rose(m_axis_tvalid) |-> $past(w_cmd.out_load), "result without query")

endmodule
